// ===== src/swls_pkg.sv =====
// Shared types and constants for the sliding-window latency statistics unit.
`timescale 1ns / 1ps
package swls_pkg;

  localparam int Window    = 32;
  localparam int PtrW      = $clog2(Window);
  localparam int CntW      = $clog2(Window + 1);
  localparam int SampleW   = 32;
  localparam int PctW      = 7;
  localparam int MeanW     = 40;
  localparam int SumW      = SampleW + PtrW;
  localparam int DivW      = SumW + 8;
  localparam int DivCntW   = $clog2(DivW + 1);
  localparam logic [PctW-1:0] PctReset = PctW'(95);
  localparam int PctScale  = 100;
  // Division by 100 as a multiply by 5243 / 2^19; exact for every count times percentile.
  localparam int RankRecip = 5243;
  localparam int RankShift = 19;
  localparam int RankMulW  = CntW + PctW + RankShift;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // write the new sample, clear accumulators
    logic scan_clr;  // start a scan over slot j (reset counters)
    logic scan_step; // process ring slot i against candidate j
    logic pick;      // register the current candidate as chosen
    logic div_start;
    logic div_step;
    logic out_load;
  } swls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_last;
    logic j_last;
    logic found;
    logic div_done;
  } swls_sts_t;

endpackage

// ===== src/swls_ctrl.sv =====
// Controller state machine sequencing the insert, scan, divide and output.
`timescale 1ns / 1ps
module swls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  swls_pkg::swls_sts_t sts,
  output swls_pkg::swls_cmd_t cmd
);
  import swls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLR, ST_SCAN, ST_DIV, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   pick_done_r, pick_done_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next-state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    pick_done_nxt = pick_done_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          pick_done_nxt = 1'b0;
          state_nxt     = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.i_last) begin
          if (sts.found && !pick_done_r) begin
            cmd.pick      = 1'b1;
            pick_done_nxt = 1'b1;
          end
          if (sts.j_last) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_CLR;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pick_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pick_done_r <= pick_done_nxt;
    end
  end

  // An item is only taken while idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  // The output register is only reloaded when free or draining.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten");
  // A load happens only from idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_CLR))
    else $error("load sequencing");

endmodule

// ===== src/swls_dp.sv =====
// Datapath: sample ring, scan counters, rank selection and mean divider.
`timescale 1ns / 1ps
module swls_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swls_pkg::swls_cmd_t           cmd,
  output swls_pkg::swls_sts_t           sts,
  input  logic [swls_pkg::SampleW-1:0]  in_sample_us,
  input  logic                          cfg_we,
  input  logic [swls_pkg::PctW-1:0]     cfg_data,
  output logic [swls_pkg::CntW-1:0]     out_sample_count,
  output logic [swls_pkg::MeanW-1:0]    out_mean_fixed,
  output logic [swls_pkg::SampleW-1:0]  out_max_sample,
  output logic [swls_pkg::SampleW-1:0]  out_percentile_sample
);
  import swls_pkg::*;

  logic [SampleW-1:0] ring [Window];
  logic [PtrW-1:0]    wp_r;
  logic [CntW-1:0]    held_r;
  logic [PctW-1:0]    pct_r;
  logic [CntW-1:0]    rank_r;
  logic [PtrW-1:0]    i_r, j_r;
  logic [CntW-1:0]    less_r, leq_r;
  logic [SampleW-1:0] cand_r;
  logic [SampleW-1:0] max_r, pick_r;
  logic [SumW-1:0]    sum_r;
  logic [DivW-1:0]    quo_r;
  logic [CntW:0]      rem_r;
  logic [DivCntW-1:0] dcnt_r;
  logic [SampleW-1:0] ring_rd_r;
  logic [CntW-1:0]    less_nxt, leq_nxt;
  logic [CntW+PctW-1:0] prod;
  logic [RankMulW-1:0]  rank_mul;
  logic [CntW+PctW-1:0] rank_raw;
  logic [CntW:0]      rem_sh;

  // ring_rd_r is a registered copy of ring slot i_r.
  assign less_nxt = less_r + CntW'(ring_rd_r < cand_r);
  assign leq_nxt  = leq_r + CntW'(ring_rd_r <= cand_r);
  assign sts.i_last = (CntW'(i_r) == held_r - 1'b1);
  assign sts.j_last = (CntW'(j_r) == held_r - 1'b1);
  // Candidate j is the rank's element if rank lies in [less, leq).
  assign sts.found = (less_nxt <= rank_r) && (rank_r < leq_nxt);
  assign sts.div_done = (dcnt_r == DivCntW'(DivW));

  // Rank: floor(n * pct / 100) by reciprocal multiplication, clamped.
  assign prod     = CntW'(held_r) * (CntW+PctW)'(pct_r);
  assign rank_mul = RankMulW'(prod) * RankMulW'(RankRecip);
  assign rank_raw = (CntW+PctW)'(rank_mul >> RankShift);
  assign rem_sh   = {rem_r[CntW-1:0], quo_r[DivW-1]};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PctReset;
    end else if (cfg_we) begin
      pct_r <= cfg_data;
    end
  end

  // Ring write and pointers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[wp_r] <= in_sample_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      held_r <= '0;
    end else if (cmd.load) begin
      wp_r <= (CntW'(wp_r) == CntW'(Window - 1)) ? '0 : wp_r + 1'b1;
      if (held_r != CntW'(Window)) begin
        held_r <= held_r + 1'b1;
      end
    end
  end

  // Scan: outer index j picks a candidate, inner index i counts ranks.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      j_r   <= '0;
      sum_r <= '0;
      max_r <= '0;
    end else if (cmd.scan_clr) begin
      i_r       <= '0;
      less_r    <= '0;
      leq_r     <= '0;
      cand_r    <= ring[j_r];
      ring_rd_r <= ring[PtrW'(0)];
      rank_r <= (rank_raw >= (CntW+PctW)'(held_r)) ? held_r - 1'b1 : CntW'(rank_raw);
    end else if (cmd.scan_step) begin
      less_r    <= less_nxt;
      leq_r     <= leq_nxt;
      i_r       <= i_r + 1'b1;
      ring_rd_r <= ring[i_r + 1'b1];
      if (j_r == '0) begin
        sum_r <= sum_r + SumW'(ring_rd_r);
        if (ring_rd_r > max_r) max_r <= ring_rd_r;
      end
      if (sts.i_last) j_r <= j_r + 1'b1;
    end
    if (cmd.pick) pick_r <= cand_r;
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // With one held sample the sum's only addition lands on this same edge.
      quo_r  <= {((j_r == '0) ? sum_r + SumW'(ring_rd_r) : sum_r), 8'h00};
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step && !sts.div_done) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (rem_sh >= {1'b0, held_r}) begin
        rem_r <= rem_sh - {1'b0, held_r};
        quo_r <= {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DivW-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_count      <= held_r;
      out_mean_fixed        <= MeanW'(quo_r);
      out_max_sample        <= max_r;
      out_percentile_sample <= pick_r;
    end
  end

  // The rank lies inside the held set during a scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (rank_r < held_r))
    else $error("rank out of range");
  // The held count never exceeds the window.
  assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CntW'(Window))
    else $error("held count overflow");
  // The divider runs only on a non-empty window.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (held_r != '0))
    else $error("divide by zero");

endmodule

// ===== src/sliding_window_latency_stats_unit.sv =====
// Top level of the sliding-window latency statistics unit.
// A new sample is taken only after the previous result is loaded into the output register;
// the pairwise rank scan over every candidate and the one-bit-per-cycle mean divider set the pace.
// Reset clears pointer, count and control; percentile resets to 95; ring is not cleared.
`timescale 1ns / 1ps
module sliding_window_latency_stats_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swls_pkg::SampleW-1:0]  in_sample_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swls_pkg::CntW-1:0]     out_sample_count,
  output logic [swls_pkg::MeanW-1:0]    out_mean_fixed,
  output logic [swls_pkg::SampleW-1:0]  out_max_sample,
  output logic [swls_pkg::SampleW-1:0]  out_percentile_sample,
  input  logic                          cfg_we,
  input  logic [swls_pkg::PctW-1:0]     cfg_data
);
  import swls_pkg::*;

  swls_cmd_t cmd;
  swls_sts_t sts;

  // Controller.
  swls_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  // Datapath.
  swls_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_sample_us(in_sample_us),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .out_sample_count(out_sample_count),
    .out_mean_fixed(out_mean_fixed), .out_max_sample(out_max_sample),
    .out_percentile_sample(out_percentile_sample)
  );

endmodule
